// ===== src/linear_hash_table_assert.svh =====
// Assertion macros shared by the RTL.
`ifndef LINEAR_HASH_TABLE_ASSERT_SVH
`define LINEAR_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define LHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/lht_pkg.sv =====
`default_nettype none

package lht_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_FILL,
    S_SRD,
    S_SCMP,
    S_SPL0,
    S_SPL1,
    S_MRD,
    S_MWR,
    S_FSP,
    S_FNB,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== src/linear_hash_table.sv =====
// Linear hash table of integer keys. Start a transaction by raising start_i
// with op_i/key_i while busy_o is low; busy_o stays high until the single
// result appears for exactly one cycle with done_o high. The result cannot be
// stalled: sample it on that cycle. A search reads every key of the addressed
// bucket; an insert that splits also moves every key of the split bucket.
// The key RAM has a single read port: every slot is read once and its data
// checked or moved on the following cycle. Keys live in a RAM of
// MAX_BUCKETS*CHAIN_SLOTS entries, bucket fill counts in a second RAM with
// one valid flop per bucket (an invalid bucket reads as empty). No clearing
// pass is needed after reset.
`default_nettype none
`include "linear_hash_table_assert.svh"

module linear_hash_table
  import lht_pkg::*;
#(
  parameter int MAX_BUCKETS     = 64,
  parameter int INITIAL_BUCKETS = 4,
  parameter int BASE_SLOTS      = 4,
  parameter int CHAIN_SLOTS     = 16,
  parameter int KEY_BITS        = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               op_i,
  input  wire logic signed [31:0] key_i,
  output logic                    done_o,
  output logic                    found_o,
  output logic [1:0]              status_o,
  output logic [5:0]              bucket_index_o,
  output logic                    did_split_o,
  output logic [6:0]              bucket_total_o
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;  // stored key width
  localparam int BW = $clog2(MAX_BUCKETS);              // bucket index
  localparam int HW = BW + 1;                           // hash work width
  localparam int NW = HW + 1;                           // new bucket calc
  localparam int CW = $clog2(MAX_BUCKETS + 1);          // bucket count
  localparam int LW = $clog2(BW + 2);                   // hash level
  localparam int FW = $clog2(CHAIN_SLOTS + 1);          // fill count
  localparam int AW = $clog2(MAX_BUCKETS * CHAIN_SLOTS);
  localparam int INIT_LVL = $clog2(INITIAL_BUCKETS + 1) - 1;

  state_e state_q, state_d;

  // control state
  logic [BW-1:0]          sp_q, sp_d;
  logic [LW-1:0]          lvl_q, lvl_d;
  logic [CW-1:0]          bkt_q, bkt_d;
  logic [MAX_BUCKETS-1:0] valid_q, valid_d;

  // per-transaction working registers
  logic          op_q, op_d;
  logic [31:0]   key_q, key_d;
  logic [BW-1:0] b_q, b_d;
  logic [BW-1:0] nb_q, nb_d;
  logic [FW-1:0] n_q, n_d;
  logic [FW-1:0] j_q, j_d;
  logic [FW-1:0] cs_q, cs_d;
  logic [FW-1:0] cn_q, cn_d;
  logic          found_q, found_d;
  logic [1:0]    status_q, status_d;
  logic          split_q, split_d;

  // RAM ports
  logic          fill_we;
  logic [BW-1:0] fill_waddr, fill_raddr;
  logic [FW-1:0] fill_wdata, fill_rdata;
  logic          key_we;
  logic [AW-1:0] key_waddr, key_raddr;
  logic [KW-1:0] key_wdata, key_rdata;

  lht_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  lht_ram #(.WIDTH(KW), .DEPTH(MAX_BUCKETS * CHAIN_SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Bucket address: lvl bits, or lvl+1 bits when below the split pointer.
  logic [HW-1:0] mask_lo, mask_hi, h_lo, h_hi, h_sel;
  logic [BW-1:0] hash_b;
  always_comb begin
    mask_lo = (HW'(1) << lvl_q) - HW'(1);
    mask_hi = (HW'(1) << (lvl_q + LW'(1))) - HW'(1);
    h_lo    = key_q[HW-1:0] & mask_lo;
    h_hi    = key_q[HW-1:0] & mask_hi;
    h_sel   = (h_lo < HW'(sp_q)) ? h_hi : h_lo;
    if (32'(h_sel) >= 32'(MAX_BUCKETS)) begin
      h_sel = '0;
    end
    hash_b = BW'(h_sel);
  end

  logic [NW-1:0] nb_w;
  logic [NW-1:0] sp_next;
  logic [NW-1:0] lvl_span;
  logic [KW-1:0] kc;
  logic [FW-1:0] n_cur;
  logic          mv_hi;
  logic [AW-1:0] base_b, base_sp, base_nb;

  assign kc       = key_q[KW-1:0];
  assign lvl_span = NW'(1) << lvl_q;
  assign nb_w     = NW'(sp_q) + lvl_span;
  assign sp_next  = NW'(sp_q) + NW'(1);
  assign mv_hi    = (key_rdata >> lvl_q) != '0 ? key_rdata[0] | 1'b1 : 1'b0;
  assign base_b   = AW'(AW'(b_q) * AW'(CHAIN_SLOTS));
  assign base_sp  = AW'(AW'(sp_q) * AW'(CHAIN_SLOTS));
  assign base_nb  = AW'(AW'(nb_q) * AW'(CHAIN_SLOTS));

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    lvl_d      = lvl_q;
    bkt_d      = bkt_q;
    valid_d    = valid_q;
    op_d       = op_q;
    key_d      = key_q;
    b_d        = b_q;
    nb_d       = nb_q;
    n_d        = n_q;
    j_d        = j_q;
    cs_d       = cs_q;
    cn_d       = cn_q;
    found_d    = found_q;
    status_d   = status_q;
    split_d    = split_q;
    fill_we    = 1'b0;
    fill_waddr = b_q;
    fill_wdata = '0;
    fill_raddr = b_q;
    key_we     = 1'b0;
    key_waddr  = base_b;
    key_wdata  = kc;
    key_raddr  = base_b;
    n_cur      = valid_q[b_q] ? fill_rdata : '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          key_d   = key_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        b_d        = hash_b;
        fill_raddr = hash_b;
        found_d    = 1'b0;
        status_d   = ST_OK;
        split_d    = 1'b0;
        state_d    = S_FILL;
      end
      S_FILL: begin
        n_d = n_cur;
        j_d = '0;
        if (op_q == OP_SEARCH) begin
          state_d = (n_cur == '0) ? S_DONE : S_SRD;
        end else if (32'(n_cur) >= 32'(CHAIN_SLOTS)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          key_we     = 1'b1;
          key_waddr  = base_b + AW'(n_cur);
          fill_we    = 1'b1;
          fill_wdata = n_cur + FW'(1);
          state_d    = S_DONE;
          if (32'(n_cur) >= 32'(BASE_SLOTS)) begin
            if (32'(bkt_q) >= 32'(MAX_BUCKETS)) begin
              status_d = ST_LIMIT;
            end else begin
              split_d = 1'b1;
              state_d = S_SPL0;
            end
          end
        end
      end
      S_SRD: begin
        key_raddr = base_b + AW'(j_q);
        state_d   = S_SCMP;
      end
      S_SCMP: begin
        if (key_rdata == kc) begin
          found_d = 1'b1;
        end
        j_d     = j_q + FW'(1);
        state_d = (j_q + FW'(1) >= n_q) ? S_DONE : S_SRD;
      end
      S_SPL0: begin
        // the new bucket equals the bucket count, so this guard never trips
        if (32'(nb_w) >= 32'(MAX_BUCKETS)) begin
          state_d = S_DONE;
        end else begin
          nb_d       = BW'(nb_w);
          fill_raddr = sp_q;
          state_d    = S_SPL1;
        end
      end
      S_SPL1: begin
        n_d     = valid_q[sp_q] ? fill_rdata : '0;
        j_d     = '0;
        cs_d    = '0;
        cn_d    = '0;
        state_d = S_MRD;
      end
      S_MRD: begin
        key_raddr = base_sp + AW'(j_q);
        state_d   = (j_q < n_q) ? S_MWR : S_FSP;
      end
      S_MWR: begin
        // compaction in place: write slot cs never passes read slot j
        key_we    = 1'b1;
        key_wdata = key_rdata;
        if (mv_hi && key_rdata[0] == key_rdata[0]
            && ((key_rdata >> lvl_q) & KW'(1)) != '0) begin
          key_waddr = base_nb + AW'(cn_q);
          cn_d      = cn_q + FW'(1);
        end else begin
          key_waddr = base_sp + AW'(cs_q);
          cs_d      = cs_q + FW'(1);
        end
        j_d     = j_q + FW'(1);
        state_d = S_MRD;
      end
      S_FSP: begin
        fill_we    = 1'b1;
        fill_waddr = sp_q;
        fill_wdata = cs_q;
        state_d    = S_FNB;
      end
      S_FNB: begin
        fill_we    = 1'b1;
        fill_waddr = nb_q;
        fill_wdata = cn_q;
        bkt_d      = bkt_q + CW'(1);
        if (sp_next >= lvl_span) begin
          sp_d  = '0;
          lvl_d = lvl_q + LW'(1);
        end else begin
          sp_d = BW'(sp_next);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fill_we) begin
      valid_d[fill_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      lvl_q   <= LW'(INIT_LVL);
      bkt_q   <= CW'(1 << INIT_LVL);
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      lvl_q   <= lvl_d;
      bkt_q   <= bkt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    b_q      <= b_d;
    nb_q     <= nb_d;
    n_q      <= n_d;
    j_q      <= j_d;
    cs_q     <= cs_d;
    cn_q     <= cn_d;
    found_q  <= found_d;
    status_q <= status_d;
    split_q  <= split_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign bucket_index_o = 6'(b_q);
  assign did_split_o    = split_q;
  assign bucket_total_o = 7'(bkt_q);

  `LHT_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `LHT_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `LHT_ASSERT_IMP(a_split_ok, clk_i, rst_ni, done_o && did_split_o, status_o == ST_OK)
  `LHT_ASSERT_IMP(a_search_clean, clk_i, rst_ni, done_o && op_q == OP_SEARCH,
                  status_o == ST_OK && !did_split_o)

endmodule

`default_nettype wire

// ===== src/lht_ram.sv =====
`default_nettype none

module lht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
